@@ design/packet_receiver_with_ack_table_unit_macros.svh @@
// Assertion macros shared by the packet receiver RTL.
`ifndef PACKET_RECEIVER_WITH_ACK_TABLE_UNIT_MACROS_SVH
`define PACKET_RECEIVER_WITH_ACK_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define PRX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("packet receiver: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define PRX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("packet receiver: next-cycle check failed");

`endif

@@ design/prxack_pkg.sv @@
// Types, codes and constants of the packet receiver with ack table.
`default_nettype none

package prxack_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_IDX_W   = 8;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_REQUIRED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_ACK       = 8'd1;
  localparam logic [7:0] ACK_REQUIRED_RESET = 8'h01;
  localparam logic [7:0] IS_ACK_RESET       = 8'h02;

  // Byte roles beyond the parse phases.
  localparam logic [3:0] ROLE_CHECKSUM = 4'd10;
  localparam logic [3:0] ROLE_EXTRA    = 4'd11;

  typedef enum logic [3:0] {
    V_BUSY          = 4'd0,
    V_BAD_CHECKSUM  = 4'd1,
    V_ACK_CLEARED   = 4'd2,
    V_ACK_UNMATCHED = 4'd3,
    V_DELIVER_REPLY = 4'd4,
    V_DELIVER       = 4'd5,
    V_REGISTERED    = 4'd6,
    V_TABLE_FULL    = 4'd7,
    V_NO_ACK        = 4'd8,
    V_TRUNCATED     = 4'd9
  } verdict_e;

  typedef enum logic [10:0] {
    PH_VERSION  = 11'b000_0000_0001,
    PH_FLAGS    = 11'b000_0000_0010,
    PH_ID_LO    = 11'b000_0000_0100,
    PH_ID_HI    = 11'b000_0000_1000,
    PH_SRC_LEN  = 11'b000_0001_0000,
    PH_SRC_CHR  = 11'b000_0010_0000,
    PH_DST_LEN  = 11'b000_0100_0000,
    PH_DST_CHR  = 11'b000_1000_0000,
    PH_PAY_LEN  = 11'b001_0000_0000,
    PH_PAY_BYTE = 11'b010_0000_0000,
    PH_DONE     = 11'b100_0000_0000
  } phase_e;

  typedef enum logic {
    CMD_RX_BYTE = 1'b0,
    CMD_SENT    = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [15:0] sent_id;
    logic [7:0]  sent_flags;
  } in_t;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  data_byte;
    logic [3:0]  verdict;
    logic [15:0] packet_id;
    logic [7:0]  packet_flags;
    logic [3:0]  pending_count;
  } out_t;

  // Role reported for a non-final byte seen in a given phase.
  function automatic logic [3:0] phase_role(input phase_e ph);
    logic [3:0] r;
    unique case (ph)
      PH_VERSION:  r = 4'd0;
      PH_FLAGS:    r = 4'd1;
      PH_ID_LO:    r = 4'd2;
      PH_ID_HI:    r = 4'd3;
      PH_SRC_LEN:  r = 4'd4;
      PH_SRC_CHR:  r = 4'd5;
      PH_DST_LEN:  r = 4'd6;
      PH_DST_CHR:  r = 4'd7;
      PH_PAY_LEN:  r = 4'd8;
      PH_PAY_BYTE: r = 4'd9;
      default:     r = ROLE_EXTRA;
    endcase
    return r;
  endfunction

  // Saturate the table occupancy to the 4-bit result field.
  function automatic logic [3:0] sat_count(input logic [CNT_W-1:0] cnt);
    logic [7:0] wide;
    wide = 8'(cnt);
    return (wide > 8'd15) ? 4'd15 : wide[3:0];
  endfunction

endpackage

`default_nettype wire

@@ design/packet_receiver_with_ack_table_unit.sv @@
// Top level of the packet receiver with pending-ack table.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one
//   transaction per received frame byte (cmd = 0) or per sent packet
//   (cmd = 1). Each transaction yields exactly one result transaction on
//   the output channel (out_valid_o / out_stall_i / out_data_o).
//   Configuration writes (cfg_valid_i / cfg_ready_o, index and data) set
//   the ack-required and is-ack flag masks; cfg_ready_o is always high. The
//   user must let writes go in only while the block is idle; the block
//   itself does not enforce this.
//   Throughput: one transaction per cycle unless in_stall_o is high, set by
//   the combinational parse step and parallel compare over all table entries.
//   Stall: the output register is backed by a one-entry skid stage, so an
//   input is still taken in the cycle the receiver starts to stall;
//   in_stall_o rises only once the skid stage holds a result.
//   Reset: parser returns to the version phase, checksum and frame fields
//   clear, every table entry goes invalid and the masks take 0x01 / 0x02.
`default_nettype none

`include "packet_receiver_with_ack_table_unit_macros.svh"

module packet_receiver_with_ack_table_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire prxack_pkg::in_t                     in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output prxack_pkg::out_t                         out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [prxack_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [7:0]                          cfg_data_i
);

  localparam int Depth = prxack_pkg::TABLE_DEPTH;
  localparam int IdxW  = prxack_pkg::IDX_W;
  localparam int CntW  = prxack_pkg::CNT_W;

  // Configuration masks.
  logic [7:0] ack_req_q, is_ack_q;

  // Parser state.
  prxack_pkg::phase_e phase_q, phase_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] fid_q, fid_d;
  logic [7:0]  fflags_q, fflags_d;

  // Pending-ack table.
  logic [15:0]     ids_q [Depth];
  logic [Depth-1:0] valid_q, valid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;

  // Lookup results.
  logic            free_found, match_found;
  logic [IdxW-1:0] free_idx, match_idx;

  // Output register and skid stage.
  logic             out_valid_q, skid_valid_q;
  prxack_pkg::out_t out_q, skid_q, res;

  logic in_fire, out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration decode; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_req_q <= prxack_pkg::ACK_REQUIRED_RESET;
      is_ack_q  <= prxack_pkg::IS_ACK_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        prxack_pkg::CFG_ACK_REQUIRED: ack_req_q <= cfg_data_i;
        prxack_pkg::CFG_IS_ACK:       is_ack_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Lowest free entry and lowest valid entry matching the frame id.
  always_comb begin
    free_found  = 1'b0;
    match_found = 1'b0;
    free_idx    = '0;
    match_idx   = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
      if (valid_q[i] && (ids_q[i] == fid_q)) begin
        match_found = 1'b1;
        match_idx   = IdxW'(i);
      end
    end
  end

  // One pass per transaction: parse step, frame check, table update.
  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    xor_d    = xor_q;
    fid_d    = fid_q;
    fflags_d = fflags_q;
    valid_d  = valid_q;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    wr_idx   = free_idx;
    res      = '0;
    res.verdict = prxack_pkg::V_BUSY;

    if (in_fire) begin
      if (in_data_i.cmd == prxack_pkg::CMD_SENT) begin
        res.packet_id    = in_data_i.sent_id;
        res.packet_flags = in_data_i.sent_flags;
        if ((in_data_i.sent_flags & ack_req_q) == 8'h00) begin
          res.verdict = prxack_pkg::V_NO_ACK;
        end else if (free_found) begin
          res.verdict       = prxack_pkg::V_REGISTERED;
          valid_d[free_idx] = 1'b1;
          wr_en             = 1'b1;
          cnt_d             = cnt_q + CntW'(1);
        end else begin
          res.verdict = prxack_pkg::V_TABLE_FULL;
        end
      end else begin
        res.data_byte = in_data_i.rx_byte;
        if (in_data_i.frame_end) begin
          res.byte_role = prxack_pkg::ROLE_CHECKSUM;
          phase_d = prxack_pkg::PH_VERSION;
          rem_d   = '0;
          xor_d   = '0;
          if (xor_q != in_data_i.rx_byte) begin
            res.verdict = prxack_pkg::V_BAD_CHECKSUM;
          end else if (phase_q != prxack_pkg::PH_DONE) begin
            res.verdict = prxack_pkg::V_TRUNCATED;
          end else begin
            res.packet_id    = fid_q;
            res.packet_flags = fflags_q;
            if ((fflags_q & is_ack_q) != 8'h00) begin
              if (match_found) begin
                res.verdict        = prxack_pkg::V_ACK_CLEARED;
                valid_d[match_idx] = 1'b0;
                cnt_d              = cnt_q - CntW'(1);
              end else begin
                res.verdict = prxack_pkg::V_ACK_UNMATCHED;
              end
            end else if ((fflags_q & ack_req_q) != 8'h00) begin
              res.verdict = prxack_pkg::V_DELIVER_REPLY;
            end else begin
              res.verdict = prxack_pkg::V_DELIVER;
            end
          end
        end else begin
          res.byte_role = prxack_pkg::phase_role(phase_q);
          xor_d = xor_q ^ in_data_i.rx_byte;
          unique case (phase_q)
            prxack_pkg::PH_VERSION: phase_d = prxack_pkg::PH_FLAGS;
            prxack_pkg::PH_FLAGS: begin
              fflags_d = in_data_i.rx_byte;
              phase_d  = prxack_pkg::PH_ID_LO;
            end
            prxack_pkg::PH_ID_LO: begin
              fid_d   = {fid_q[15:8], in_data_i.rx_byte};
              phase_d = prxack_pkg::PH_ID_HI;
            end
            prxack_pkg::PH_ID_HI: begin
              fid_d   = {in_data_i.rx_byte, fid_q[7:0]};
              phase_d = prxack_pkg::PH_SRC_LEN;
            end
            prxack_pkg::PH_SRC_LEN: begin
              rem_d   = in_data_i.rx_byte;
              phase_d = (in_data_i.rx_byte != 8'h00) ? prxack_pkg::PH_SRC_CHR
                                                      : prxack_pkg::PH_DST_LEN;
            end
            prxack_pkg::PH_DST_LEN: begin
              rem_d   = in_data_i.rx_byte;
              phase_d = (in_data_i.rx_byte != 8'h00) ? prxack_pkg::PH_DST_CHR
                                                      : prxack_pkg::PH_PAY_LEN;
            end
            prxack_pkg::PH_PAY_LEN: begin
              rem_d   = in_data_i.rx_byte;
              phase_d = (in_data_i.rx_byte != 8'h00) ? prxack_pkg::PH_PAY_BYTE
                                                      : prxack_pkg::PH_DONE;
            end
            prxack_pkg::PH_SRC_CHR: begin
              rem_d = rem_q - 8'd1;
              if (rem_d == 8'h00) phase_d = prxack_pkg::PH_DST_LEN;
            end
            prxack_pkg::PH_DST_CHR: begin
              rem_d = rem_q - 8'd1;
              if (rem_d == 8'h00) phase_d = prxack_pkg::PH_PAY_LEN;
            end
            prxack_pkg::PH_PAY_BYTE: begin
              rem_d = rem_q - 8'd1;
              if (rem_d == 8'h00) phase_d = prxack_pkg::PH_DONE;
            end
            default: phase_d = prxack_pkg::PH_DONE;
          endcase
        end
      end
    end
    res.pending_count = prxack_pkg::sat_count(cnt_d);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= prxack_pkg::PH_VERSION;
      rem_q    <= '0;
      xor_q    <= '0;
      fid_q    <= '0;
      fflags_q <= '0;
      valid_q  <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      xor_q    <= xor_d;
      fid_q    <= fid_d;
      fflags_q <= fflags_d;
      valid_q  <= valid_d;
      cnt_q    <= cnt_d;
    end
  end

  // Table ids hold until overwritten; no reset needed.
  always_ff @(posedge clk_i) begin
    if (wr_en) ids_q[wr_idx] <= in_data_i.sent_id;
  end

  // Output register with skid stage: advance when the receiver takes a
  // result or is empty, else hold and park a new result in the skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  `PRX_ASSERT_NOW(a_skid_implies_out, skid_valid_q, out_valid_q)
  `PRX_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid_q) == int'(cnt_q))
  `PRX_ASSERT_NEXT(a_frame_end_resets, in_fire && !in_data_i.cmd && in_data_i.frame_end,
                   phase_q == prxack_pkg::PH_VERSION && xor_q == 8'h00)
  `PRX_ASSERT_NEXT(a_register_grows, in_fire && res.verdict == prxack_pkg::V_REGISTERED,
                   cnt_q == CntW'($past(cnt_q) + CntW'(1)))

endmodule

`default_nettype wire
